FILE: sv/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, widths and constants for the polar-to-Cartesian scan converter.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int DEF_INDEX_BITS    = 12;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int COORD_W  = 17;
    localparam int GAIN_W   = 24;
    localparam int X_W      = 43;   // Q24 datapath with headroom for CORDIC gain
    localparam int Z_W      = 34;   // 2^32 units per turn plus sign and guard

    localparam int ATAN_ENTRIES = 24;
    localparam int ROUND_SHIFT  = 24;

    localparam logic [GAIN_W-1:0] INV_GAIN_Q24 = 24'd10188014;
    localparam logic signed [X_W-1:0] ROUND_HALF = 43'sd8388608;
    localparam logic signed [X_W-1:0] OUT_POS_LIMIT = 43'sd65535;
    localparam logic signed [X_W-1:0] OUT_NEG_LIMIT = -43'sd65535;

    // Configuration register indexes
    localparam logic REG_START_ANGLE = 1'b0;
    localparam logic REG_ANGLE_STEP  = 1'b1;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } cordic_vec_t;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic signed [Z_W-1:0] atan_turn32(input int i);
        logic signed [Z_W-1:0] t;
        case (i)
            0:  t = 34'sd536870912;
            1:  t = 34'sd316933406;
            2:  t = 34'sd167458907;
            3:  t = 34'sd85004756;
            4:  t = 34'sd42667331;
            5:  t = 34'sd21354465;
            6:  t = 34'sd10679838;
            7:  t = 34'sd5340245;
            8:  t = 34'sd2670163;
            9:  t = 34'sd1335087;
            10: t = 34'sd667544;
            11: t = 34'sd333772;
            12: t = 34'sd166886;
            13: t = 34'sd83443;
            14: t = 34'sd41721;
            15: t = 34'sd20860;
            16: t = 34'sd10430;
            17: t = 34'sd5215;
            18: t = 34'sd2607;
            19: t = 34'sd1303;
            20: t = 34'sd651;
            21: t = 34'sd325;
            22: t = 34'sd162;
            23: t = 34'sd81;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

FILE: sv/spc_cordic_cell.sv
// ----------------------------------------------------------------------------
// spc_cordic_cell
// One rotation-mode CORDIC micro-rotation with its pipeline register.
// ----------------------------------------------------------------------------
module spc_cordic_cell
    import spc_pkg::*;
#(
    parameter int IDX_W = DEF_INDEX_BITS,
    parameter int STAGE = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  cordic_vec_t      in_vec,
    input  logic             in_flip,
    input  logic [IDX_W-1:0] in_idx,
    output logic             out_valid,
    output cordic_vec_t      out_vec,
    output logic             out_flip,
    output logic [IDX_W-1:0] out_idx
);

    localparam logic signed [Z_W-1:0] ATAN = atan_turn32(STAGE);

    logic        valid_reg;
    cordic_vec_t vec_reg;
    cordic_vec_t vec_next;
    logic        flip_reg;
    logic [IDX_W-1:0] idx_reg;

    always_comb begin
        vec_next = in_vec;
        if (STAGE < ATAN_ENTRIES) begin
            if (!in_vec.z[Z_W-1]) begin
                vec_next.x = in_vec.x - (in_vec.y >>> STAGE);
                vec_next.y = in_vec.y + (in_vec.x >>> STAGE);
                vec_next.z = in_vec.z - ATAN;
            end else begin
                vec_next.x = in_vec.x + (in_vec.y >>> STAGE);
                vec_next.y = in_vec.y - (in_vec.x >>> STAGE);
                vec_next.z = in_vec.z + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg  <= vec_next;
            flip_reg <= in_flip;
            idx_reg  <= in_idx;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_flip  = flip_reg;
    assign out_idx   = idx_reg;

endmodule

FILE: sv/spc_output.sv
// ----------------------------------------------------------------------------
// spc_output
// Rounds the Q24 CORDIC vector, undoes the half-turn fold and saturates.
// ----------------------------------------------------------------------------
module spc_output
    import spc_pkg::*;
#(
    parameter int IDX_W = DEF_INDEX_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  cordic_vec_t        in_vec,
    input  logic               in_flip,
    input  logic [IDX_W-1:0]   in_idx,
    output logic               out_valid,
    output logic [COORD_W-1:0] x_coord,
    output logic [COORD_W-1:0] y_coord,
    output logic [IDX_W-1:0]   index_echo
);

    logic               valid_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [COORD_W-1:0] x_next;
    logic [COORD_W-1:0] y_next;

    function automatic logic [COORD_W-1:0] finish(input logic signed [X_W-1:0] v,
                                                  input logic flip);
        logic signed [X_W-1:0] r;
        logic signed [X_W-1:0] s;
        r = (v + ROUND_HALF) >>> ROUND_SHIFT;
        s = flip ? -r : r;
        if (s > OUT_POS_LIMIT) begin
            s = OUT_POS_LIMIT;
        end else if (s < OUT_NEG_LIMIT) begin
            s = OUT_NEG_LIMIT;
        end
        return s[COORD_W-1:0];
    endfunction

    assign x_next = finish(in_vec.x, in_flip);
    assign y_next = finish(in_vec.y, in_flip);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            idx_reg <= in_idx;
        end
    end

    assign out_valid  = valid_reg;
    assign x_coord    = x_reg;
    assign y_coord    = y_reg;
    assign index_echo = idx_reg;

endmodule

FILE: sv/scan_polar_to_cartesian.sv
// Throughput: one request per cycle; the whole pipeline (angle multiply,
// fold and gain multiply, one register per CORDIC cell, output rounding)
// advances together and holds only while a result waits on m_tready.
// Reset: synchronous active-low aresetn empties the pipeline and clears
// start_angle and angle_step to zero.
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian
// Pipelined range/angle to x/y converter built from a chain of CORDIC cells.
// ----------------------------------------------------------------------------
module scan_polar_to_cartesian
    import spc_pkg::*;
#(
    parameter int INDEX_BITS    = DEF_INDEX_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    localparam int IN_DATA_W  = ((RANGE_W + INDEX_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * COORD_W + INDEX_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic                  cfg_addr,
    input  logic [ANGLE_W-1:0]    cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // range_sample, sample_index
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // x_coord, y_coord, index_echo
);

    localparam int PROD_W = RANGE_W + GAIN_W;

    logic [ANGLE_W-1:0] start_angle_reg;
    logic [ANGLE_W-1:0] angle_step_reg;

    logic en;

    // stage A: step * index
    logic                  a_valid_reg;
    logic [ANGLE_W-1:0]    a_offset_reg;
    logic [RANGE_W-1:0]    a_range_reg;
    logic [INDEX_BITS-1:0] a_idx_reg;
    logic [ANGLE_W+INDEX_BITS-1:0] step_prod;

    // stage B: fold into right half plane, pre-scale range
    logic [ANGLE_W-1:0]    angle;
    logic                  fold;
    logic [ANGLE_W-1:0]    folded;
    logic [PROD_W-1:0]     gain_prod;
    logic                  b_valid_reg;
    cordic_vec_t           b_vec_reg;
    cordic_vec_t           b_vec_next;
    logic                  b_flip_reg;
    logic [INDEX_BITS-1:0] b_idx_reg;

    // cell chain
    logic                  cell_valid [CORDIC_STAGES+1];
    cordic_vec_t           cell_vec   [CORDIC_STAGES+1];
    logic                  cell_flip  [CORDIC_STAGES+1];
    logic [INDEX_BITS-1:0] cell_idx   [CORDIC_STAGES+1];

    logic [COORD_W-1:0]    x_coord;
    logic [COORD_W-1:0]    y_coord;
    logic [INDEX_BITS-1:0] index_echo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_START_ANGLE: start_angle_reg <= cfg_wdata;
                REG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance everything unless a finished result is blocked
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign step_prod = (ANGLE_W+INDEX_BITS)'(angle_step_reg)
                     * (ANGLE_W+INDEX_BITS)'(s_tdata[RANGE_W +: INDEX_BITS]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_offset_reg <= step_prod[ANGLE_W-1:0];
            a_range_reg  <= s_tdata[RANGE_W-1:0];
            a_idx_reg    <= s_tdata[RANGE_W +: INDEX_BITS];
        end
    end

    assign angle     = start_angle_reg + a_offset_reg;
    // left half plane: top two bits differ
    assign fold      = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
    assign folded    = {angle[ANGLE_W-1] ^ fold, angle[ANGLE_W-2:0]};
    assign gain_prod = PROD_W'(a_range_reg) * PROD_W'(INV_GAIN_Q24);

    always_comb begin
        b_vec_next.x = {{(X_W-PROD_W){1'b0}}, gain_prod};
        b_vec_next.y = '0;
        b_vec_next.z = {{(Z_W-2*ANGLE_W){folded[ANGLE_W-1]}}, folded, {ANGLE_W{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_vec_reg  <= b_vec_next;
            b_flip_reg <= fold;
            b_idx_reg  <= a_idx_reg;
        end
    end

    assign cell_valid[0] = b_valid_reg;
    assign cell_vec[0]   = b_vec_reg;
    assign cell_flip[0]  = b_flip_reg;
    assign cell_idx[0]   = b_idx_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        spc_cordic_cell #(
            .IDX_W (INDEX_BITS),
            .STAGE (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cell_valid[g]),
            .in_vec    (cell_vec[g]),
            .in_flip   (cell_flip[g]),
            .in_idx    (cell_idx[g]),
            .out_valid (cell_valid[g+1]),
            .out_vec   (cell_vec[g+1]),
            .out_flip  (cell_flip[g+1]),
            .out_idx   (cell_idx[g+1])
        );
    end

    spc_output #(
        .IDX_W (INDEX_BITS)
    ) u_output (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (cell_valid[CORDIC_STAGES]),
        .in_vec     (cell_vec[CORDIC_STAGES]),
        .in_flip    (cell_flip[CORDIC_STAGES]),
        .in_idx     (cell_idx[CORDIC_STAGES]),
        .out_valid  (m_tvalid),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .index_echo (index_echo)
    );

    assign m_tdata = OUT_DATA_W'({index_echo, y_coord, x_coord});

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !a_valid_reg && !b_valid_reg)
        else $error("pipeline not empty after reset");

    a_sat_symmetric: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> x_coord != 17'h10000 && y_coord != 17'h10000)
        else $error("coordinate outside saturation limits");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(a_valid_reg) && $stable(b_valid_reg)
            && $stable(cell_valid[CORDIC_STAGES]))
        else $error("pipeline moved during stall");

    // top two angle bits of the folded angle agree
    a_fold_right_half: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && en |=> b_vec_reg.z[Z_W-1] == b_vec_reg.z[Z_W-4])
        else $error("folded angle outside right half plane");
`endif

endmodule
